[rtl/c2dr_pkg.sv]
// Package for the conv2d forward ReLU unit: operation codes, register
// indexes, queue entry type, back-end states and fixed-point accumulator width. No dependencies.
`timescale 1ns / 1ps
package c2dr_pkg;
    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_BIAS   = 2'd1,
        OP_LOAD_SAMPLE = 2'd2,
        OP_COMPUTE     = 2'd3
    } op_t;

    localparam logic [2:0] REG_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_STRIDER = 3'd2;
    localparam logic [2:0] REG_STRIDEC = 3'd3;
    localparam logic [2:0] REG_PADR    = 3'd4;
    localparam logic [2:0] REG_PADC    = 3'd5;
    localparam logic [2:0] REG_NIC     = 3'd6;
    localparam logic [2:0] REG_NOC     = 3'd7;

    localparam int ACC_W = 48;

    // one queued request from front to back
    typedef struct packed {
        op_t         op;
        logic [3:0]  oc;
        logic [2:0]  ic;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [1:0]  kr;
        logic [1:0]  kc;
        logic [15:0] value;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH,
        ST_OUT
    } state_t;
endpackage

[rtl/conv2d_forward_relu_unit.sv]
// Top level of the conv2d forward ReLU unit: front queue plus back end.
// Depends on c2dr_pkg, c2dr_front and c2dr_back.
`timescale 1ns / 1ps
// Loads are written into the stores as they leave the queue. A compute
// request walks its in_channels * KERNEL_H * KERNEL_W taps, one tap a cycle,
// through the single multiply-accumulate
// fed by the weight and image memory ports, then the pipeline drains and the
// sum is rounded. Out-of-range requests go straight to the result beat with
// request_error set. A four-deep queue lets loads be accepted while a compute
// is in progress.
module conv2d_forward_relu_unit
#(
    parameter int MAX_HEIGHT = 32,
    parameter int MAX_WIDTH = 32,
    parameter int MAX_IN_CHANNELS = 8,
    parameter int MAX_OUT_CHANNELS = 16,
    parameter int KERNEL_H = 3,
    parameter int KERNEL_W = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation, out_channel, in_channel, row, col, kernel_row, kernel_col, value
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // activation, request_error
    output logic [15:0] m_tdata
);
    c2dr_pkg::req_t in_req, q_req;
    logic q_valid, q_pop, err;
    logic [14:0] act;

    always_comb
    begin
        in_req.op = c2dr_pkg::op_t'(s_tdata[1:0]);
        in_req.oc = s_tdata[5:2];
        in_req.ic = s_tdata[8:6];
        in_req.row = s_tdata[14:9];
        in_req.col = s_tdata[20:15];
        in_req.kr = s_tdata[22:21];
        in_req.kc = s_tdata[24:23];
        in_req.value = s_tdata[40:25];
    end

    c2dr_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    c2dr_back #(
        .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH),
        .MAX_IN_CHANNELS(MAX_IN_CHANNELS), .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
        .KERNEL_H(KERNEL_H), .KERNEL_W(KERNEL_W)
    ) u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_act(act), .out_err(err)
    );

    assign m_tdata = {err, act};
endmodule

[rtl/c2dr_front.sv]
// Front end: accepts request beats and pushes them into a short queue.
// Depends on c2dr_pkg.
`timescale 1ns / 1ps
module c2dr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  c2dr_pkg::req_t  in_req,
    output logic            q_valid,
    input  logic            q_pop,
    output c2dr_pkg::req_t  q_req
);
    c2dr_pkg::req_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic push;

    assign in_ready = cnt_reg != 3'd4;
    assign push = in_valid && in_ready;
    assign q_valid = cnt_reg != 3'd0;
    assign q_req = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, q_pop && q_valid};
        end
    end
endmodule

[rtl/c2dr_back.sv]
// Back end: stores, tap sequencer and shared multiply-accumulate.
// Depends on c2dr_pkg.
`timescale 1ns / 1ps
module c2dr_back
#(
    parameter int MAX_HEIGHT = 32,
    parameter int MAX_WIDTH = 32,
    parameter int MAX_IN_CHANNELS = 8,
    parameter int MAX_OUT_CHANNELS = 16,
    parameter int KERNEL_H = 3,
    parameter int KERNEL_W = 3
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [5:0]      cfg_data,
    input  logic            q_valid,
    output logic            q_pop,
    input  c2dr_pkg::req_t  q_req,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [14:0]     out_act,
    output logic            out_err
);
    localparam int TAPS = KERNEL_H * KERNEL_W;
    localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * TAPS;
    localparam int IDEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WAW = $clog2(WDEPTH);
    localparam int IAW = $clog2(IDEPTH);
    localparam int KHW = $clog2(KERNEL_H + 1);
    localparam int KWW = $clog2(KERNEL_W + 1);
    localparam int ACC_W = c2dr_pkg::ACC_W;

    logic [5:0] h_reg, w_reg;
    logic [2:0] sr_reg, sc_reg;
    logic [1:0] pr_reg, pc_reg;
    logic [3:0] nic_reg;
    logic [4:0] noc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= 6'd32;
            w_reg <= 6'd32;
            sr_reg <= 3'd1;
            sc_reg <= 3'd1;
            pr_reg <= '0;
            pc_reg <= '0;
            nic_reg <= 4'd1;
            noc_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                c2dr_pkg::REG_HEIGHT:  h_reg <= cfg_data;
                c2dr_pkg::REG_WIDTH:   w_reg <= cfg_data;
                c2dr_pkg::REG_STRIDER: sr_reg <= cfg_data[2:0];
                c2dr_pkg::REG_STRIDEC: sc_reg <= cfg_data[2:0];
                c2dr_pkg::REG_PADR:    pr_reg <= cfg_data[1:0];
                c2dr_pkg::REG_PADC:    pc_reg <= cfg_data[1:0];
                c2dr_pkg::REG_NIC:     nic_reg <= cfg_data[3:0];
                c2dr_pkg::REG_NOC:     noc_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // effective sizes (the user must keep the registers static while the block works; the block does not enforce it)
    logic signed [10:0] h_e, w_e, sr_e, sc_e, nic_e, noc_e, pr_e, pc_e;
    logic signed [10:0] span_h, span_w, oh, ow;
    always_comb
    begin
        h_e = (11'(h_reg) > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : 11'(h_reg);
        w_e = (11'(w_reg) > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : 11'(w_reg);
        sr_e = (sr_reg == 3'd0) ? 11'sd1 : 11'(sr_reg);
        sc_e = (sc_reg == 3'd0) ? 11'sd1 : 11'(sc_reg);
        nic_e = (11'(nic_reg) > 11'(MAX_IN_CHANNELS)) ? 11'(MAX_IN_CHANNELS)
                                                      : 11'(nic_reg);
        noc_e = (11'(noc_reg) > 11'(MAX_OUT_CHANNELS)) ? 11'(MAX_OUT_CHANNELS)
                                                       : 11'(noc_reg);
        pr_e = 11'(pr_reg);
        pc_e = 11'(pc_reg);
        span_h = h_e + 11'sd2 * pr_e;
        span_w = w_e + 11'sd2 * pc_e;
    end

    // output size: span minus kernel stays below 70, so divide by the
    // stride 1..7 with a 17-bit reciprocal multiply, exact over that range
    function automatic logic signed [10:0] osize(input logic signed [10:0] inn,
                                                 input logic signed [10:0] sp,
                                                 input logic signed [10:0] k,
                                                 input logic signed [10:0] s);
        logic signed [10:0] d;
        logic [16:0] recip;
        logic [31:0] prod;
        begin
            d = sp - k;
            unique case (s[2:0])
                3'd2: recip = 17'd32768;
                3'd3: recip = 17'd21846;
                3'd4: recip = 17'd16384;
                3'd5: recip = 17'd13108;
                3'd6: recip = 17'd10923;
                3'd7: recip = 17'd9363;
                default: recip = 17'd65536;
            endcase
            prod = 32'(d[9:0]) * 32'(recip);
            if (inn <= 0 || sp < k)
            begin
                osize = '0;
            end
            else
            begin
                osize = 11'(prod >> 16) + 11'sd1;
            end
        end
    endfunction

    assign oh = osize(h_e, span_h, 11'(KERNEL_H), sr_e);
    assign ow = osize(w_e, span_w, 11'(KERNEL_W), sc_e);

    logic signed [15:0] wmem [WDEPTH];
    logic signed [15:0] imem [IDEPTH];
    logic signed [15:0] bias_reg [MAX_OUT_CHANNELS];

    c2dr_pkg::state_t st_reg, st_next;
    c2dr_pkg::req_t cur_reg;
    logic [3:0] c_reg;
    logic [KHW-1:0] ky_reg;
    logic [KWW-1:0] kx_reg;
    logic signed [10:0] y0_reg, x0_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0] wq_reg, sq_reg;
    logic rd_v_reg, prod_v_reg;
    logic signed [31:0] prod_reg;
    logic [14:0] act_reg;
    logic err_reg;

    logic signed [10:0] iy, ix;
    logic tap_in, last_tap;
    assign iy = y0_reg + 11'(ky_reg);
    assign ix = x0_reg + 11'(kx_reg);
    assign tap_in = iy >= 0 && iy < h_e && ix >= 0 && ix < w_e;
    assign last_tap = (ky_reg == KHW'(KERNEL_H - 1)) && (kx_reg == KWW'(KERNEL_W - 1))
                      && (11'(c_reg) + 11'sd1 >= nic_e);

    logic q_is_load, q_bad;
    assign q_is_load = q_req.op != c2dr_pkg::OP_COMPUTE;
    assign q_bad = 11'(q_req.oc) >= noc_e || 11'(q_req.row) >= oh || 11'(q_req.col) >= ow;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            c2dr_pkg::ST_IDLE:
                if (q_valid && !q_is_load) st_next = q_bad ? c2dr_pkg::ST_OUT
                                                           : c2dr_pkg::ST_SETUP;
            c2dr_pkg::ST_SETUP:
                st_next = (nic_e == 0) ? c2dr_pkg::ST_DRAIN : c2dr_pkg::ST_RUN;
            c2dr_pkg::ST_RUN:
                if (last_tap) st_next = c2dr_pkg::ST_DRAIN;
            c2dr_pkg::ST_DRAIN:
                if (!rd_v_reg && !prod_v_reg) st_next = c2dr_pkg::ST_FINISH;
            c2dr_pkg::ST_FINISH:
                st_next = c2dr_pkg::ST_OUT;
            c2dr_pkg::ST_OUT:
                if (out_ready) st_next = c2dr_pkg::ST_IDLE;
            default: st_next = c2dr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (st_reg == c2dr_pkg::ST_IDLE) && q_valid;
        out_valid = st_reg == c2dr_pkg::ST_OUT;
        out_act = act_reg;
        out_err = err_reg;
    end

    logic [WAW-1:0] wld_a, wrd_a;
    logic [IAW-1:0] ild_a, ird_a;
    assign wld_a = WAW'((32'(q_req.oc) * MAX_IN_CHANNELS + 32'(q_req.ic)) * TAPS
                   + 32'(q_req.kr) * KERNEL_W + 32'(q_req.kc));
    assign ild_a = IAW'((32'(q_req.ic) * MAX_HEIGHT + 32'(q_req.row)) * MAX_WIDTH
                   + 32'(q_req.col));
    assign wrd_a = WAW'((32'(cur_reg.oc) * MAX_IN_CHANNELS + 32'(c_reg)) * TAPS
                   + 32'(ky_reg) * KERNEL_W + 32'(kx_reg));
    assign ird_a = IAW'((32'(c_reg) * MAX_HEIGHT + 32'(iy[9:0])) * MAX_WIDTH
                   + 32'(ix[9:0]));

    // stores: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (q_pop && q_req.op == c2dr_pkg::OP_LOAD_WEIGHT && 32'(q_req.oc) < MAX_OUT_CHANNELS
            && 32'(q_req.ic) < MAX_IN_CHANNELS && 32'(q_req.kr) < KERNEL_H
            && 32'(q_req.kc) < KERNEL_W)
        begin
            wmem[wld_a] <= q_req.value;
        end
        if (q_pop && q_req.op == c2dr_pkg::OP_LOAD_SAMPLE && 32'(q_req.ic) < MAX_IN_CHANNELS
            && 32'(q_req.row) < MAX_HEIGHT && 32'(q_req.col) < MAX_WIDTH)
        begin
            imem[ild_a] <= q_req.value;
        end
        wq_reg <= wmem[wrd_a];
        sq_reg <= imem[ird_a];
        prod_reg <= wq_reg * sq_reg;
    end

    logic signed [ACC_W-1:0] rnd;
    assign rnd = (acc_reg + ACC_W'(128)) >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= c2dr_pkg::ST_IDLE;
            rd_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
            for (int i = 0; i < MAX_OUT_CHANNELS; i++)
            begin
                bias_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            rd_v_reg <= (st_reg == c2dr_pkg::ST_RUN) && tap_in;
            prod_v_reg <= rd_v_reg;
            if (q_pop && q_req.op == c2dr_pkg::OP_LOAD_BIAS
                && 32'(q_req.oc) < MAX_OUT_CHANNELS)
            begin
                bias_reg[q_req.oc] <= q_req.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            c2dr_pkg::ST_IDLE:
            begin
                cur_reg <= q_req;
                err_reg <= q_bad;
                act_reg <= '0;
            end
            c2dr_pkg::ST_SETUP:
            begin
                c_reg <= '0;
                ky_reg <= '0;
                kx_reg <= '0;
                y0_reg <= 11'(32'(cur_reg.row) * 32'(sr_e)) - pr_e;
                x0_reg <= 11'(32'(cur_reg.col) * 32'(sc_e)) - pc_e;
                acc_reg <= ACC_W'(bias_reg[cur_reg.oc]) <<< 8;
            end
            c2dr_pkg::ST_RUN:
            begin
                // advance kx, then ky, then channel
                if (kx_reg == KWW'(KERNEL_W - 1))
                begin
                    kx_reg <= '0;
                    if (ky_reg == KHW'(KERNEL_H - 1))
                    begin
                        ky_reg <= '0;
                        c_reg <= c_reg + 4'd1;
                    end
                    else
                    begin
                        ky_reg <= ky_reg + KHW'(1);
                    end
                end
                else
                begin
                    kx_reg <= kx_reg + KWW'(1);
                end
            end
            c2dr_pkg::ST_FINISH:
            begin
                if (acc_reg <= 0) act_reg <= '0;
                else if (rnd > ACC_W'(32767)) act_reg <= 15'h7fff;
                else act_reg <= rnd[14:0];
            end
            default: ;
        endcase
        if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end
endmodule

[rtl/conv2d_forward_relu_unit_chk.sv]
// Port-level checker for the conv2d forward ReLU unit, bound to the top.
// Depends on conv2d_forward_relu_unit.
`timescale 1ns / 1ps
module conv2d_forward_relu_unit_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[14:0] == 15'd0)
        else $error("error result with nonzero activation");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result back to back without idle");
endmodule

bind conv2d_forward_relu_unit conv2d_forward_relu_unit_chk u_chk
(
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
